### hw/rtl/tods_pkg.sv
// Shared types and constants for the time-of-day setter with auto-repeat.
// Used by the channel interfaces and the top level; no dependencies.
package tods_pkg;

  // Field widths
  localparam int TIME_BITS     = 17;
  localparam int NOW_BITS      = 32;
  localparam int MS_BITS       = 16;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  // Time-of-day constants in seconds
  localparam logic [TIME_BITS-1:0] DAY_SECONDS  = 17'd86400;
  localparam logic [TIME_BITS-1:0] LAST_SECOND  = 17'd86399;
  localparam logic [TIME_BITS-1:0] NOON_SECONDS = 17'd43200;
  localparam logic [TIME_BITS-1:0] STEP_SECONDS = 17'd60;
  localparam logic [TIME_BITS-1:0] DOWN_WRAP    = 17'd86340;

  // Register reset values
  localparam logic [MS_BITS-1:0] SLOW_RESET  = 16'd150;
  localparam logic [MS_BITS-1:0] FAST_RESET  = 16'd10;
  localparam logic [MS_BITS-1:0] ACCEL_RESET = 16'd2000;

  // Button positions in the level and flag vectors
  localparam int BTN_DOWN    = 0;
  localparam int BTN_UP      = 1;
  localparam int BTN_CONFIRM = 2;
  localparam int BTN_ESCAPE  = 3;
  localparam int NUM_BUTTONS = 4;

  // Configuration register indexes (word address)
  typedef enum logic [1:0] {
    REG_MODE_24H = 2'd0,
    REG_SLOW     = 2'd1,
    REG_FAST     = 2'd2,
    REG_ACCEL    = 2'd3
  } cfg_reg_t;

  // One accepted poll
  typedef struct packed {
    logic                   start_req;
    logic [TIME_BITS-1:0]   start_seconds;
    logic [NOW_BITS-1:0]    now_ms;
    logic [NUM_BUTTONS-1:0] levels;
  } poll_t;

  // One result item
  typedef struct packed {
    logic [TIME_BITS-1:0] time_value;
    logic                 pm_lamp;
    logic                 session_active;
    logic                 finished;
    logic                 cancelled;
  } result_t;

endpackage

### hw/rtl/tods_poll_if.sv
// Poll channel: valid/ready handshake carrying one button poll.
// Depends on tods_pkg for field widths.
interface tods_poll_if;
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic [tods_pkg::TIME_BITS-1:0] start_seconds;
  logic [tods_pkg::NOW_BITS-1:0]  now_ms;
  logic                          down_level;
  logic                          up_level;
  logic                          confirm_level;
  logic                          escape_level;

  modport source (
    output valid, start_req, start_seconds, now_ms,
           down_level, up_level, confirm_level, escape_level,
    input  ready
  );

  modport sink (
    input  valid, start_req, start_seconds, now_ms,
           down_level, up_level, confirm_level, escape_level,
    output ready
  );
endinterface

### hw/rtl/tods_result_if.sv
// Result channel: valid/ready handshake carrying one setter result.
// Depends on tods_pkg for field widths.
interface tods_result_if;
  logic                          valid;
  logic                          ready;
  logic [tods_pkg::TIME_BITS-1:0] time_value;
  logic                          pm_lamp;
  logic                          session_active;
  logic                          finished;
  logic                          cancelled;

  modport source (
    output valid, time_value, pm_lamp, session_active, finished, cancelled,
    input  ready
  );

  modport sink (
    input  valid, time_value, pm_lamp, session_active, finished, cancelled,
    output ready
  );
endinterface

### hw/rtl/time_of_day_setter_auto_repeat.sv
// A poll transfer is captured in the input register, processed once the result
// buffer has room and stored in the two-entry result buffer behind the result port.
// Throughput: one poll per cycle unless the buffer is full and not being popped;
// the buffer keeps polls flowing while a result waits. All state updates are one
// pass of compare/add logic. Reset (rst, synchronous): buttons released, stamps
// and time zero, session off, registers at defaults; takes effect at a clock edge.
// Depends on tods_pkg, tods_poll_if and tods_result_if.
module time_of_day_setter_auto_repeat #(
  parameter int STAMP_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  tods_poll_if.sink                          poll,
  tods_result_if.source                      result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tods_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [tods_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [tods_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam logic [1:0] RES_DEPTH = 2'd2;

  // Configuration registers
  logic                          mode_24h;
  logic [tods_pkg::MS_BITS-1:0]  slow_repeat_ms;
  logic [tods_pkg::MS_BITS-1:0]  fast_repeat_ms;
  logic [tods_pkg::MS_BITS-1:0]  accel_after_ms;
  tods_pkg::cfg_reg_t            cfg_sel;
  logic                          cfg_write;

  // Input register
  logic                          in_valid;
  tods_pkg::poll_t               in_item;

  // Session state
  logic [tods_pkg::NUM_BUTTONS-1:0] button_flags;
  logic [STAMP_BITS-1:0]            last_change [tods_pkg::NUM_BUTTONS];
  logic [STAMP_BITS-1:0]            press_start [2];
  logic [tods_pkg::TIME_BITS-1:0]   seconds_of_day;
  logic [tods_pkg::MS_BITS-1:0]     repeat_delay;
  logic                             lamp_on;
  logic                             running;

  logic [tods_pkg::NUM_BUTTONS-1:0] button_flags_next;
  logic [STAMP_BITS-1:0]            last_change_next [tods_pkg::NUM_BUTTONS];
  logic [STAMP_BITS-1:0]            press_start_next [2];
  logic [tods_pkg::TIME_BITS-1:0]   seconds_next;
  logic [tods_pkg::MS_BITS-1:0]     repeat_delay_next;
  logic                             lamp_next;
  logic                             running_next;
  logic                             done_next;
  logic                             abort_next;

  // Per-item decode
  logic [STAMP_BITS-1:0]            now_s;
  logic [tods_pkg::NUM_BUTTONS-1:0] lv;
  logic [tods_pkg::NUM_BUTTONS-1:0] press_edge;
  logic [tods_pkg::NUM_BUTTONS-1:0] release_edge;
  logic [tods_pkg::TIME_BITS-1:0]   start_sat;
  logic [STAMP_BITS-1:0]            ps_down;
  logic [STAMP_BITS-1:0]            ps_up;
  logic                             rep_down;
  logic                             rep_up;
  logic                             step_down;
  logic                             step_up;
  logic [tods_pkg::MS_BITS-1:0]     delay_mid;
  logic [tods_pkg::MS_BITS-1:0]     delay_fin;
  logic [tods_pkg::TIME_BITS-1:0]   sec_mid;
  logic [tods_pkg::TIME_BITS-1:0]   sec_up_sum;
  logic [tods_pkg::TIME_BITS-1:0]   sec_fin;

  // Result buffer
  tods_pkg::result_t                res_slot [2];
  tods_pkg::result_t                res_new;
  logic [1:0]                       res_count;
  logic                             res_pop;
  logic                             proc;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = tods_pkg::cfg_reg_t'(paddr[tods_pkg::CFG_ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_24h       <= 1'b0;
      slow_repeat_ms <= tods_pkg::SLOW_RESET;
      fast_repeat_ms <= tods_pkg::FAST_RESET;
      accel_after_ms <= tods_pkg::ACCEL_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        tods_pkg::REG_MODE_24H: mode_24h       <= pwdata[0];
        tods_pkg::REG_SLOW:     slow_repeat_ms <= pwdata[tods_pkg::MS_BITS-1:0];
        tods_pkg::REG_FAST:     fast_repeat_ms <= pwdata[tods_pkg::MS_BITS-1:0];
        tods_pkg::REG_ACCEL:    accel_after_ms <= pwdata[tods_pkg::MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_sel)
      tods_pkg::REG_MODE_24H: prdata = {31'd0, mode_24h};
      tods_pkg::REG_SLOW:     prdata = {16'd0, slow_repeat_ms};
      tods_pkg::REG_FAST:     prdata = {16'd0, fast_repeat_ms};
      tods_pkg::REG_ACCEL:    prdata = {16'd0, accel_after_ms};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and flow control
  // ---------------------------------------------------------------------------
  assign res_pop    = result.valid && result.ready;
  assign proc       = in_valid && ((res_count != RES_DEPTH) || res_pop);
  assign poll.ready = !in_valid || proc;

  // Capture a poll on transfer, drop it once processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_item.start_req     <= poll.start_req;
      in_item.start_seconds <= poll.start_seconds;
      in_item.now_ms        <= poll.now_ms;
      in_item.levels        <= {poll.escape_level, poll.confirm_level,
                                poll.up_level, poll.down_level};
    end
  end

  // ---------------------------------------------------------------------------
  // Edge detection, repeat timing and time stepping
  // ---------------------------------------------------------------------------
  assign now_s        = STAMP_BITS'(in_item.now_ms);
  assign lv           = in_item.levels;
  assign press_edge   = lv & ~button_flags;
  assign release_edge = ~lv & button_flags;
  assign start_sat    = (in_item.start_seconds >= tods_pkg::DAY_SECONDS)
                        ? tods_pkg::LAST_SECOND : in_item.start_seconds;

  // Press start as seen after tracking a press edge
  assign ps_down = press_edge[tods_pkg::BTN_DOWN] ? now_s : press_start[0];
  assign ps_up   = press_edge[tods_pkg::BTN_UP]   ? now_s : press_start[1];

  // Down: held repeat against the current delay
  assign rep_down  = lv[tods_pkg::BTN_DOWN] && button_flags[tods_pkg::BTN_DOWN] &&
                     ((now_s - last_change[tods_pkg::BTN_DOWN]) >=
                      STAMP_BITS'(repeat_delay));
  assign step_down = press_edge[tods_pkg::BTN_DOWN] || rep_down;
  assign delay_mid = !step_down ? repeat_delay :
                     ((now_s - ps_down) > STAMP_BITS'(accel_after_ms))
                     ? fast_repeat_ms : slow_repeat_ms;
  assign sec_mid   = !step_down ? seconds_of_day :
                     (seconds_of_day < tods_pkg::STEP_SECONDS)
                     ? tods_pkg::DOWN_WRAP : seconds_of_day - tods_pkg::STEP_SECONDS;

  // Up: held repeat against the delay that down may have just set
  assign rep_up     = lv[tods_pkg::BTN_UP] && button_flags[tods_pkg::BTN_UP] &&
                      ((now_s - last_change[tods_pkg::BTN_UP]) >=
                       STAMP_BITS'(delay_mid));
  assign step_up    = press_edge[tods_pkg::BTN_UP] || rep_up;
  assign delay_fin  = !step_up ? delay_mid :
                      ((now_s - ps_up) > STAMP_BITS'(accel_after_ms))
                      ? fast_repeat_ms : slow_repeat_ms;
  assign sec_up_sum = sec_mid + tods_pkg::STEP_SECONDS;
  assign sec_fin    = !step_up ? sec_mid :
                      (sec_up_sum >= tods_pkg::DAY_SECONDS) ? '0 : sec_up_sum;

  // Next session state for the item in the input register
  always_comb begin
    button_flags_next = button_flags;
    for (int b = 0; b < tods_pkg::NUM_BUTTONS; b++) begin
      last_change_next[b] = last_change[b];
    end
    press_start_next[0] = press_start[0];
    press_start_next[1] = press_start[1];
    seconds_next        = seconds_of_day;
    repeat_delay_next   = repeat_delay;
    lamp_next           = lamp_on;
    running_next        = running;
    done_next           = 1'b0;
    abort_next          = 1'b0;

    if (in_item.start_req) begin
      seconds_next      = start_sat;
      repeat_delay_next = slow_repeat_ms;
      running_next      = 1'b1;
    end else if (!running) begin
      // Idle: track all buttons
      button_flags_next = lv;
      for (int b = 0; b < tods_pkg::NUM_BUTTONS; b++) begin
        if (press_edge[b] || release_edge[b]) begin
          last_change_next[b] = now_s;
        end
      end
      if (press_edge[tods_pkg::BTN_DOWN]) begin
        press_start_next[0] = now_s;
      end
      if (press_edge[tods_pkg::BTN_UP]) begin
        press_start_next[1] = now_s;
      end
    end else begin
      // Escape is tracked on every poll in a session that carries no start request
      button_flags_next[tods_pkg::BTN_ESCAPE] = lv[tods_pkg::BTN_ESCAPE];
      if (press_edge[tods_pkg::BTN_ESCAPE] || release_edge[tods_pkg::BTN_ESCAPE]) begin
        last_change_next[tods_pkg::BTN_ESCAPE] = now_s;
      end
      if (press_edge[tods_pkg::BTN_ESCAPE]) begin
        abort_next   = 1'b1;
        lamp_next    = 1'b0;
        running_next = 1'b0;
      end else begin
        button_flags_next[tods_pkg::BTN_CONFIRM] = lv[tods_pkg::BTN_CONFIRM];
        if (press_edge[tods_pkg::BTN_CONFIRM] || release_edge[tods_pkg::BTN_CONFIRM]) begin
          last_change_next[tods_pkg::BTN_CONFIRM] = now_s;
        end
        if (press_edge[tods_pkg::BTN_CONFIRM]) begin
          done_next    = 1'b1;
          lamp_next    = 1'b0;
          running_next = 1'b0;
        end else begin
          // Step down, then up
          button_flags_next[tods_pkg::BTN_DOWN] = lv[tods_pkg::BTN_DOWN];
          button_flags_next[tods_pkg::BTN_UP]   = lv[tods_pkg::BTN_UP];
          if (step_down || release_edge[tods_pkg::BTN_DOWN]) begin
            last_change_next[tods_pkg::BTN_DOWN] = now_s;
          end
          if (step_up || release_edge[tods_pkg::BTN_UP]) begin
            last_change_next[tods_pkg::BTN_UP] = now_s;
          end
          press_start_next[0] = ps_down;
          press_start_next[1] = ps_up;
          seconds_next        = sec_fin;
          repeat_delay_next   = delay_fin;
          if (step_up) begin
            lamp_next = (sec_fin >= tods_pkg::NOON_SECONDS) && !mode_24h;
          end else if (step_down) begin
            lamp_next = (sec_mid >= tods_pkg::NOON_SECONDS) && !mode_24h;
          end
          if (!lv[tods_pkg::BTN_DOWN] && !lv[tods_pkg::BTN_UP]) begin
            lamp_next = 1'b0;
          end
        end
      end
    end
  end

  // Advance session state on each processed poll
  always_ff @(posedge clk) begin
    if (rst) begin
      button_flags   <= '0;
      for (int b = 0; b < tods_pkg::NUM_BUTTONS; b++) begin
        last_change[b] <= '0;
      end
      press_start[0] <= '0;
      press_start[1] <= '0;
      seconds_of_day <= '0;
      repeat_delay   <= tods_pkg::SLOW_RESET;
      lamp_on        <= 1'b0;
      running        <= 1'b0;
    end else if (proc) begin
      button_flags   <= button_flags_next;
      for (int b = 0; b < tods_pkg::NUM_BUTTONS; b++) begin
        last_change[b] <= last_change_next[b];
      end
      press_start[0] <= press_start_next[0];
      press_start[1] <= press_start_next[1];
      seconds_of_day <= seconds_next;
      repeat_delay   <= repeat_delay_next;
      lamp_on        <= lamp_next;
      running        <= running_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry result buffer
  // ---------------------------------------------------------------------------
  assign res_new.time_value     = seconds_next;
  assign res_new.pm_lamp        = lamp_next;
  assign res_new.session_active = running_next;
  assign res_new.finished       = done_next;
  assign res_new.cancelled      = abort_next;

  // Hold the occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
    end else if (proc && !res_pop) begin
      res_count <= res_count + 2'd1;
    end else if (res_pop && !proc) begin
      res_count <= res_count - 2'd1;
    end
  end

  // Shift on transfer out, fill the first free slot
  always_ff @(posedge clk) begin
    if (proc && ((res_count == 2'd0) || (res_pop && (res_count == 2'd1)))) begin
      res_slot[0] <= res_new;
    end else if (res_pop) begin
      res_slot[0] <= res_slot[1];
    end
    if (proc && (res_count != 2'd0) && !(res_pop && (res_count == 2'd1))) begin
      res_slot[1] <= res_new;
    end
  end

  assign result.valid          = (res_count != 2'd0);
  assign result.time_value     = res_slot[0].time_value;
  assign result.pm_lamp        = res_slot[0].pm_lamp;
  assign result.session_active = res_slot[0].session_active;
  assign result.finished       = res_slot[0].finished;
  assign result.cancelled      = res_slot[0].cancelled;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_DEPTH)
    else $error("result buffer overfilled");

  a_proc_shows: assert property (@(posedge clk) disable iff (rst)
    proc |=> result.valid)
    else $error("processed poll left no result");

  a_end_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.finished && result.cancelled))
    else $error("finished and cancelled together");

  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.finished || result.cancelled) |-> !result.session_active)
    else $error("session still active after it ended");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    proc |=> seconds_of_day < tods_pkg::DAY_SECONDS)
    else $error("time of day out of range");
`endif

endmodule
